// ----- rtl/aenv_pkg.sv -----
package aenv_pkg;

  // Default build values
  localparam int HALF_MAX_DEF    = 31;
  localparam int STORE_DEPTH_DEF = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  // Fixed field widths
  localparam int WINDOW_W = 6;   // window_size register
  localparam int SEEN_W   = 6;   // samples_seen counter, saturates at its top
  localparam int H_W      = 5;   // half width, never above 31

endpackage

// ----- rtl/aenv_ram.sv -----
module aenv_ram
  import aenv_pkg::*;
#(
  parameter int WIDTH = SAMPLE_BITS_DEF,
  parameter int DEPTH = STORE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write one word, read one word with registered output
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/abs_envelope_moving_average.sv -----
// Absolute-amplitude envelope with an optional centered moving average. Each input item is a
// signed sample plus an end-of-stream flag; each result is either the sample's magnitude
// (window_size 0) or the floored mean of the magnitudes within h samples on each side, clipped
// at both stream ends, h being ceil(window_size/2) capped at H_LIM. Results lag their samples
// by h items, and the item flagged stream_end flushes all pending results, oldest first, with
// final_result set on the last one. Magnitudes live in a circular RAM of STORE_DEPTH words
// with one read port, so each result takes one RAM read per cycle to build the sum of the N
// samples averaged (1 to 2h+1), then one quotient bit per cycle from the restoring divider,
// and is pushed once the output register is free. An item that yields no result leaves the
// block idle. The input is taken only while no result is being computed; a finished result
// waits in the output register without holding back the next item. window_size may be written
// only while idle.
module abs_envelope_moving_average
  import aenv_pkg::*;
#(
  parameter int HALF_MAX    = HALF_MAX_DEF,
  parameter int STORE_DEPTH = STORE_DEPTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // window_size register write
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [WINDOW_W-1:0]           cfg_window_size,
  // sample items
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_stream_end,
  // envelope items
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [SAMPLE_BITS-1:0]        out_envelope_value,
  output logic                          out_final_result
);

  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int DIV_W  = $clog2(STORE_DEPTH + 1);
  localparam int SUM_W  = SAMPLE_BITS - 1 + $clog2(STORE_DEPTH);
  localparam int STEP_W = $clog2(SUM_W + 1);
  localparam int H_LIM  = (HALF_MAX < (STORE_DEPTH - 1) / 2) ? HALF_MAX
                                                              : (STORE_DEPTH - 1) / 2;
  localparam logic [WINDOW_W:0]   H_LIM_W  = (WINDOW_W + 1)'(H_LIM);
  localparam logic [H_W-1:0]      H_LIM_H  = H_W'(H_LIM);
  localparam logic [SEEN_W-1:0]   SEEN_TOP = {SEEN_W{1'b1}};
  localparam logic [SEEN_W-1:0]   TOP_LIM  = SEEN_W'(STORE_DEPTH - 1);
  localparam logic [ADDR_W-1:0]   ADDR_TOP = ADDR_W'(STORE_DEPTH - 1);
  localparam logic [STEP_W-1:0]   STEP_END = STEP_W'(SUM_W - 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_TOP  = 5'b00010,
    S_SUM  = 5'b00100,
    S_DIV  = 5'b01000,
    S_PUSH = 5'b10000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [WINDOW_W-1:0]    ws_r, ws_nxt;
  logic [SEEN_W-1:0]      seen_r, seen_nxt;
  logic [ADDR_W-1:0]      ptr_r, ptr_nxt;
  logic [H_W-1:0]         h_r, h_nxt;
  logic [SEEN_W-1:0]      n_r, n_nxt;
  logic [H_W-1:0]         k_r, k_nxt;
  logic                   last_r, last_nxt;
  logic [DIV_W-1:0]       cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]      rd_addr_r, rd_addr_nxt;
  logic [DIV_W-1:0]       iss_r, iss_nxt;
  logic                   dv_r, dv_nxt;
  logic [SUM_W-1:0]       acc_r, acc_nxt;
  logic [DIV_W-1:0]       rem_r, rem_nxt;
  logic [STEP_W-1:0]      step_r, step_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [SAMPLE_BITS-1:0] out_env_r, out_env_nxt;
  logic                   out_fin_r, out_fin_nxt;

  logic                   in_acc;
  logic [SAMPLE_BITS-1:0] samp_u;
  logic [SAMPLE_BITS-1:0] mag;
  logic [WINDOW_W:0]      h_raw;
  logic [H_W-1:0]         h_c;
  logic                   n_lt_h;
  logic [H_W-1:0]         k_first;
  logic [ADDR_W-1:0]      wptr;
  logic [SEEN_W-1:0]      kh;
  logic [SEEN_W-1:0]      t1;
  logic [SEEN_W-1:0]      top_c;
  logic                   issue;
  logic [DIV_W:0]         rem_sh;
  logic                   q_bit;
  logic [DIV_W:0]         rem_sub;
  logic                   push_ok;
  logic [SAMPLE_BITS-1:0] ram_rdata;

  assign in_acc    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  // Magnitude of the incoming sample; the most negative code maps to 2^(SAMPLE_BITS-1)
  assign samp_u = $unsigned(in_sample);
  assign mag    = samp_u[SAMPLE_BITS-1] ? (~samp_u + SAMPLE_BITS'(1)) : samp_u;

  // Half width from the current setting, saturated
  assign h_raw   = ({1'b0, ws_r} + (WINDOW_W + 1)'(1)) >> 1;
  assign h_c     = (h_raw > H_LIM_W) ? H_LIM_H : h_raw[H_W-1:0];
  assign n_lt_h  = seen_r < SEEN_W'(h_c);
  assign k_first = (in_stream_end && n_lt_h) ? seen_r[H_W-1:0] : h_c;

  // Next write slot in the circular store
  assign wptr = (ptr_r == ADDR_TOP) ? '0 : ptr_r + ADDR_W'(1);

  // Last window position for the current result: min(k + h, n, depth - 1)
  assign kh    = SEEN_W'(k_r) + SEEN_W'(h_r);
  assign t1    = (kh < n_r) ? kh : n_r;
  assign top_c = (t1 > TOP_LIM) ? TOP_LIM : t1;

  assign issue = (state_r == S_SUM) && (iss_r != cnt_r);

  // One restoring division step
  assign rem_sh  = {rem_r, acc_r[SUM_W-1]};
  assign q_bit   = rem_sh >= {1'b0, cnt_r};
  assign rem_sub = rem_sh - {1'b0, cnt_r};

  assign push_ok = !out_valid_r || out_ready;

  aenv_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (in_acc),
    .waddr (wptr),
    .wdata (mag),
    .raddr (rd_addr_r),
    .rdata (ram_rdata)
  );

  // Sequence one item: store, then per result sum, divide and push
  always_comb begin
    state_nxt     = state_r;
    ws_nxt        = ws_r;
    seen_nxt      = seen_r;
    ptr_nxt       = ptr_r;
    h_nxt         = h_r;
    n_nxt         = n_r;
    k_nxt         = k_r;
    last_nxt      = last_r;
    cnt_nxt       = cnt_r;
    rd_addr_nxt   = rd_addr_r;
    iss_nxt       = iss_r;
    dv_nxt        = 1'b0;
    acc_nxt       = acc_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_env_nxt   = out_env_r;
    out_fin_nxt   = out_fin_r;

    if (cfg_valid && cfg_ready) begin
      ws_nxt = cfg_window_size;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          ptr_nxt  = wptr;
          h_nxt    = h_c;
          n_nxt    = seen_r;
          k_nxt    = k_first;
          last_nxt = in_stream_end;
          if (in_stream_end) begin
            seen_nxt = '0;
          end else if (seen_r != SEEN_TOP) begin
            seen_nxt = seen_r + SEEN_W'(1);
          end
          if (in_stream_end || !n_lt_h) begin
            state_nxt = S_TOP;
          end
        end
      end
      S_TOP: begin
        cnt_nxt     = DIV_W'(top_c) + DIV_W'(1);
        rd_addr_nxt = ptr_r;
        iss_nxt     = '0;
        acc_nxt     = '0;
        state_nxt   = S_SUM;
      end
      S_SUM: begin
        // Issue one read per cycle, newest first; add each word in the following cycle
        if (issue) begin
          rd_addr_nxt = (rd_addr_r == '0) ? ADDR_TOP : rd_addr_r - ADDR_W'(1);
          iss_nxt     = iss_r + DIV_W'(1);
          dv_nxt      = 1'b1;
        end
        if (dv_r) begin
          acc_nxt = acc_r + SUM_W'(ram_rdata);
        end
        if (!issue && !dv_r) begin
          rem_nxt   = '0;
          step_nxt  = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        // Shift in one quotient bit per cycle
        rem_nxt  = q_bit ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
        acc_nxt  = {acc_r[SUM_W-2:0], q_bit};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_END) begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        // Hand the result to the output register once it is free
        if (push_ok) begin
          out_valid_nxt = 1'b1;
          out_env_nxt   = acc_r[SAMPLE_BITS-1:0];
          out_fin_nxt   = last_r && (k_r == '0);
          if (last_r && (k_r != '0)) begin
            k_nxt     = k_r - H_W'(1);
            state_nxt = S_TOP;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ws_r        <= '0;
      seen_r      <= '0;
      ptr_r       <= '0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ws_r        <= ws_nxt;
      seen_r      <= seen_nxt;
      ptr_r       <= ptr_nxt;
      dv_r        <= dv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    h_r       <= h_nxt;
    n_r       <= n_nxt;
    k_r       <= k_nxt;
    last_r    <= last_nxt;
    cnt_r     <= cnt_nxt;
    rd_addr_r <= rd_addr_nxt;
    iss_r     <= iss_nxt;
    acc_r     <= acc_nxt;
    rem_r     <= rem_nxt;
    step_r    <= step_nxt;
    out_env_r <= out_env_nxt;
    out_fin_r <= out_fin_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_envelope_value = out_env_r;
  assign out_final_result   = out_fin_r;

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps

module testbench
  import aenv_pkg::*;
;

  localparam int SAMPLE_W    = SAMPLE_BITS_DEF;
  localparam int DEPTH       = STORE_DEPTH_DEF;
  localparam int HALF_LIMIT  = (HALF_MAX_DEF < (STORE_DEPTH_DEF - 1) / 2) ?
                               HALF_MAX_DEF : (STORE_DEPTH_DEF - 1) / 2;
  localparam int SEEN_TOP    = (1 << SEEN_W) - 1;
  localparam int SETTLE      = 150;
  localparam int CYCLE_LIMIT = 10000000;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 16;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       stream_end;
  } sample_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic                is_last;
  } envelope_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [WINDOW_W-1:0]        cfg_window_size = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_sample = '0;
  logic                       in_stream_end = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [SAMPLE_W-1:0]        out_envelope_value;
  logic                       out_final_result;

  abs_envelope_moving_average dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_window_size    (cfg_window_size),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_sample          (in_sample),
    .in_stream_end      (in_stream_end),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_envelope_value (out_envelope_value),
    .out_final_result   (out_final_result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Envelope predictor state
  logic [SAMPLE_W:0]   mag_history [DEPTH];
  logic [SEEN_W-1:0]   stream_count = '0;
  logic [WINDOW_W-1:0] window_len = '0;

  sample_item_t sample_backlog [$];
  envelope_t    envelope_due [$];

  int unsigned planned_items = 0;
  int unsigned accepted_items = 0;
  int unsigned window_writes = 0;
  int unsigned cycle_count = 0;
  bit          failed = 1'b0;
  bit          in_quiet = 1'b0;
  bit          out_quiet = 1'b0;
  bit          in_taken = 1'b0;
  bit          out_taken = 1'b0;
  int unsigned in_gap = 0;
  int unsigned out_hold = 0;

  function automatic int unsigned draw_wait(input bit quiet);
    return quiet ? 0 : $urandom_range(0, 16);
  endfunction

  function automatic int half_reach();
    int h;
    h = (int'(window_len) + 1) / 2;
    if (h > HALF_LIMIT) h = HALF_LIMIT;
    return h;
  endfunction

  // Shift in the new magnitude and queue every envelope value this sample releases
  function automatic void predict_envelope(input sample_item_t item);
    int        h;
    int        n;
    int        k_first;
    int        k_last;
    int        top;
    int        total;
    bit        emits;
    envelope_t res;
    h = half_reach();
    n = int'(stream_count);
    for (int i = DEPTH - 1; i > 0; i--) mag_history[i] = mag_history[i-1];
    if (item.sample[SAMPLE_W-1]) begin
      mag_history[0] = (SAMPLE_W + 1)'((1 << SAMPLE_W) - int'({1'b0, item.sample}));
    end else begin
      mag_history[0] = {1'b0, item.sample};
    end
    emits = 1'b1;
    if (item.stream_end) begin
      k_first = (n < h) ? n : h;
      k_last = 0;
    end else if (n >= h) begin
      k_first = h;
      k_last = h;
    end else begin
      emits = 1'b0;
      k_first = 0;
      k_last = 0;
    end
    if (emits) begin
      for (int k = k_first; k >= k_last; k--) begin
        top = k + h;
        if (top > n) top = n;
        if (top > DEPTH - 1) top = DEPTH - 1;
        total = 0;
        for (int i = 0; i <= top; i++) total += int'(mag_history[i]);
        res.value = SAMPLE_W'(total / (top + 1));
        res.is_last = item.stream_end && (k == k_last);
        envelope_due.push_back(res);
      end
    end
    // Clear the stream count at the end mark, else saturate it
    if (item.stream_end) stream_count = '0;
    else if (stream_count < SEEN_TOP) stream_count = stream_count + 1'b1;
  endfunction

  // Feed sample items, holding each until accepted, then wait out its gap
  always @(negedge clk) begin : feed
    sample_item_t item;
    if (rst_n) begin
      if (in_valid && !in_taken) begin
        // hold the current item
      end else if (in_gap != 0) begin
        in_valid <= 1'b0;
        in_gap = in_gap - 1;
      end else if (sample_backlog.size() != 0) begin
        item = sample_backlog.pop_front();
        in_valid <= 1'b1;
        in_sample <= item.sample;
        in_stream_end <= item.stream_end;
        in_gap = draw_wait(in_quiet);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Stall the result side for a random number of cycles after each item
  always @(negedge clk) begin : drain
    if (rst_n) begin
      if (out_taken) out_hold = draw_wait(out_quiet);
      if (out_hold != 0) begin
        out_ready <= 1'b0;
        out_hold = out_hold - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Track register writes, predict on accepted samples, check envelope items
  always @(posedge clk) begin : monitor
    sample_item_t taken;
    envelope_t    due;
    if (!rst_n) begin
      in_taken <= 1'b0;
      out_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      out_taken <= out_valid && out_ready;
      if (cfg_valid && cfg_ready) begin
        window_len = cfg_window_size;
        window_writes++;
      end
      if (in_valid && in_ready) begin
        taken.sample = in_sample;
        taken.stream_end = in_stream_end;
        predict_envelope(taken);
        accepted_items++;
      end
      if (out_valid && out_ready) begin
        if (envelope_due.size() == 0) begin
          $error("unexpected envelope item: envelope_value %0d, final_result %0b",
                 out_envelope_value, out_final_result);
          failed = 1'b1;
        end else begin
          due = envelope_due.pop_front();
          if (out_envelope_value !== due.value) begin
            $error("envelope_value: expected %0d, got %0d", due.value, out_envelope_value);
            failed = 1'b1;
          end
          if (out_final_result !== due.is_last) begin
            $error("final_result: expected %0b, got %0b", due.is_last, out_final_result);
            failed = 1'b1;
          end
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic add_item(input int value, input bit closes);
    sample_item_t item;
    item.sample = value[SAMPLE_W-1:0];
    item.stream_end = closes;
    sample_backlog.push_back(item);
    planned_items++;
  endtask

  // Write window_size; the block must be idle
  task automatic write_window(input int value);
    int unsigned target;
    target = window_writes + 1;
    @(negedge clk);
    cfg_window_size <= value[WINDOW_W-1:0];
    cfg_valid <= 1'b1;
    wait (window_writes == target);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait for every item to go through, then let the block go idle
  task automatic settle();
    while (accepted_items != planned_items || envelope_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic int pick_sample();
    case ($urandom_range(0, 7))
      0: return -(1 << (SAMPLE_W - 1));
      1: return (1 << (SAMPLE_W - 1)) - 1;
      2: return int'($urandom_range(0, 32)) - 16;
      default: return int'($urandom_range(0, (1 << SAMPLE_W) - 1));
    endcase
  endfunction

  initial begin : stimulus
    int window_plan [6] = '{62, 63, 0, 1, 2, 61};
    int count;
    int len;
    bit closes;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Plain magnitudes: extremes, and a one-sample stream
    write_window(0);
    add_item(32767, 1'b0);
    add_item(-32768, 1'b0);
    add_item(-1, 1'b0);
    add_item(0, 1'b1);
    add_item(1, 1'b1);
    settle();

    // Narrow window: one-sample stream of the most negative sample, then a short stream
    in_quiet = 1'b1;
    write_window(2);
    add_item(-32768, 1'b1);
    add_item(100, 1'b0);
    add_item(-200, 1'b0);
    add_item(300, 1'b1);
    settle();

    // Over-wide setting clips to the widest window, stream shorter than the window
    in_quiet = 1'b0;
    out_quiet = 1'b1;
    write_window(63);
    add_item(32767, 1'b0);
    add_item(-32768, 1'b0);
    add_item(-32768, 1'b0);
    add_item(7, 1'b0);
    add_item(-5, 1'b0);
    add_item(0, 1'b1);
    settle();

    // Change the window in the middle of a stream
    out_quiet = 1'b0;
    write_window(1);
    add_item(10, 1'b0);
    add_item(-20, 1'b0);
    add_item(30, 1'b0);
    add_item(40, 1'b0);
    settle();
    write_window(5);
    add_item(50, 1'b0);
    add_item(60, 1'b0);
    add_item(-70, 1'b1);
    settle();

    // Random streams under a setting written per phase, some left open across a write
    for (int p = 0; p < PHASES; p++) begin
      in_quiet = ($urandom_range(0, 3) == 0);
      out_quiet = ($urandom_range(0, 3) == 0);
      write_window((p < 6) ? window_plan[p] : int'($urandom_range(0, 63)));
      count = 0;
      while (count < PHASE_ITEMS) begin
        len = ($urandom_range(0, 7) == 0) ? int'($urandom_range(64, 90)) :
                                            int'($urandom_range(1, 24));
        closes = ($urandom_range(0, 5) != 0);
        for (int i = 0; i < len; i++) add_item(pick_sample(), closes && (i == len - 1));
        count += len;
      end
      settle();
    end

    // Close whatever stream is still open
    add_item(pick_sample(), 1'b1);
    settle();

    if (!failed) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/aenv_pkg.sv
rtl/aenv_ram.sv
rtl/abs_envelope_moving_average.sv
test/testbench.sv
